>>> rtl/srsc_pkg.sv
// ============================================================================
// srsc_pkg
// Types, codes and constants shared by the sector request splitter.
// ============================================================================
`default_nettype none

package srsc_pkg;

    localparam int LIN_W       = 12;
    localparam int CYL_W       = 11;
    localparam int SEC_W       = 6;
    localparam int OFFS_W      = 10;
    localparam int SEG_W       = 11;
    localparam int OFF_W       = 22;
    localparam int LEN_W       = 13;
    localparam int TOTAL_W     = 13;
    localparam int LAST_W      = 16;
    localparam int MIN_SHIFT   = 7;
    localparam int FIFO_DEPTH  = 2;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam int NUM_HEADS_DEF         = 2;
    localparam int MAX_REQUEST_BYTES_DEF = 4096;

    localparam logic [1:0]         RST_SIZE_CODE = 2'd2;
    localparam logic [SEC_W-1:0]   RST_SPT       = 6'd18;
    localparam logic [TOTAL_W-1:0] RST_TOTAL     = 13'd2880;
    localparam logic [TOTAL_W-1:0] SECTOR_LIMIT  = 13'd4096;

    localparam logic [1:0] REG_SIZE_CODE = 2'd0;
    localparam logic [1:0] REG_SPT       = 2'd1;
    localparam logic [1:0] REG_TOTAL     = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]         size_code;
        logic [SEC_W-1:0]   spt;
        logic [TOTAL_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [LIN_W-1:0]  first;
        logic [LIN_W-1:0]  last;
        logic [OFFS_W-1:0] offs;
        logic [LEN_W-1:0]  len;
        status_t           status;
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [LIN_W-1:0]  linear;
        logic [CYL_W-1:0]  cyl;
        logic              head;
        logic [SEC_W-1:0]  sector;
        logic [OFFS_W-1:0] offs;
        logic [SEG_W-1:0]  seg;
        logic              last;
        status_t           status;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/srsc_front.sv
// ============================================================================
// srsc_front
// Accepts requests, finds first and last sector and classifies them.
// ============================================================================
`default_nettype none

module srsc_front #(
    parameter int MAX_REQUEST_BYTES = srsc_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  wire srsc_pkg::cfg_t                  cfg,
    input  wire logic                            kind,
    input  wire logic [srsc_pkg::OFF_W-1:0]      start_offset,
    input  wire logic [srsc_pkg::LEN_W-1:0]      byte_count,
    output srsc_pkg::req_t                       req
);
    import srsc_pkg::*;

    logic [OFF_W:0]    end_byte;
    logic [3:0]        shift;
    logic [LAST_W-1:0] last_sec;
    logic [OFF_W-1:0]  first_full;
    logic [OFFS_W-1:0] offs_mask;

    always_comb
    begin
        shift      = 4'(MIN_SHIFT) + 4'(cfg.size_code);
        end_byte   = (OFF_W+1)'(start_offset) + (OFF_W+1)'(byte_count) - (OFF_W+1)'(1);
        last_sec   = LAST_W'(end_byte >> shift);
        first_full = start_offset >> shift;
        offs_mask  = OFFS_W'((11'd128 << cfg.size_code) - 11'd1);

        req.kind   = kind;
        req.first  = first_full[LIN_W-1:0];
        req.last   = last_sec[LIN_W-1:0];
        req.offs   = start_offset[OFFS_W-1:0] & offs_mask;
        req.len    = byte_count;
        if (byte_count == '0)
        begin
            req.status = ST_EMPTY;
        end
        else if (byte_count > LEN_W'(MAX_REQUEST_BYTES)
                 || last_sec >= LAST_W'(cfg.limit))
        begin
            req.status = ST_RANGE;
        end
        else
        begin
            req.status = ST_OK;
        end
    end

endmodule

`default_nettype wire

>>> rtl/srsc_fifo.sv
// ============================================================================
// srsc_fifo
// Short request queue between the front and back parts.
// ============================================================================
`default_nettype none

module srsc_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire srsc_pkg::req_t  wr_data,
    output logic                 full,
    input  wire logic            pop,
    output srsc_pkg::req_t       rd_data,
    output logic                 empty
);
    import srsc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    req_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/srsc_back.sv
// ============================================================================
// srsc_back
// Maps the first sector of an OK request to CHS by a serial divider, then
// emits one segment per cycle into the output register unless stalled.
// ============================================================================
`default_nettype none

module srsc_back #(
    parameter int NUM_HEADS = srsc_pkg::NUM_HEADS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire srsc_pkg::cfg_t  cfg,
    input  wire srsc_pkg::req_t  req,
    input  wire logic            req_empty,
    output logic                 req_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output srsc_pkg::res_t       out_data
);
    import srsc_pkg::*;

    localparam int CNT_W = $clog2(LIN_W + 1);

    back_state_t       state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic              kind_reg, kind_next;
    status_t           status_reg, status_next;
    logic [LIN_W-1:0]  cur_reg, cur_next;
    logic [LIN_W-1:0]  last_reg, last_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LIN_W-1:0]  dvd_reg, dvd_next;
    logic [SEC_W-1:0]  drem_reg, drem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CYL_W-1:0]  cyl_reg, cyl_next;
    logic              head_reg, head_next;
    logic [SEC_W-1:0]  sidx_reg, sidx_next;

    logic              out_free;
    logic [SEC_W:0]    trial;
    logic              ge;
    logic [SEG_W-1:0]  size;
    logic [SEG_W-1:0]  room;
    logic [SEG_W-1:0]  seg;
    logic              at_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        trial = {drem_reg, dvd_reg[LIN_W-1]};
        ge    = (trial >= (SEC_W+1)'(cfg.spt));
        size  = SEG_W'(11'd128 << cfg.size_code);
        room  = size - SEG_W'(offs_reg);
        seg   = (LEN_W'(room) > rem_reg) ? rem_reg[SEG_W-1:0] : room;
        at_last = (cur_reg == last_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        offs_next      = offs_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        cnt_next       = cnt_reg;
        cyl_next       = cyl_reg;
        head_next      = head_reg;
        sidx_next      = sidx_reg;
        req_pop        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!req_empty)
                begin
                    req_pop     = 1'b1;
                    kind_next   = req.kind;
                    status_next = req.status;
                    cur_next    = req.first;
                    last_next   = req.last;
                    offs_next   = req.offs;
                    rem_next    = req.len;
                    dvd_next    = req.first;
                    drem_next   = '0;
                    cnt_next    = CNT_W'(LIN_W);
                    state_next  = (req.status == ST_OK) ? BK_DIV : BK_EMIT;
                end
            end
            BK_DIV:
            begin
                drem_next = ge ? SEC_W'(trial - (SEC_W+1)'(cfg.spt)) : trial[SEC_W-1:0];
                dvd_next  = {dvd_reg[LIN_W-2:0], ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cyl_next   = CYL_W'(dvd_next / NUM_HEADS);
                    head_next  = 1'(dvd_next % NUM_HEADS);
                    sidx_next  = drem_next;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (status_reg != ST_OK)
                    begin
                        out_next        = '0;
                        out_next.kind   = kind_reg;
                        out_next.last   = 1'b1;
                        out_next.status = status_reg;
                        state_next      = BK_IDLE;
                    end
                    else
                    begin
                        out_next.kind   = kind_reg;
                        out_next.linear = cur_reg;
                        out_next.cyl    = cyl_reg;
                        out_next.head   = head_reg;
                        out_next.sector = sidx_reg + 1'b1;
                        out_next.offs   = offs_reg;
                        out_next.seg    = seg;
                        out_next.last   = at_last;
                        out_next.status = ST_OK;
                        cur_next  = cur_reg + 1'b1;
                        offs_next = '0;
                        rem_next  = rem_reg - LEN_W'(seg);
                        if (sidx_reg + 1'b1 == cfg.spt)
                        begin
                            sidx_next = '0;
                            if (head_reg == 1'(NUM_HEADS - 1))
                            begin
                                head_next = 1'b0;
                                cyl_next  = cyl_reg + 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sidx_next = sidx_reg + 1'b1;
                        end
                        if (at_last)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        offs_reg   <= offs_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        drem_reg   <= drem_next;
        cyl_reg    <= cyl_next;
        head_reg   <= head_next;
        sidx_reg   <= sidx_next;
    end

endmodule

`default_nettype wire

>>> rtl/sector_request_splitter_chs.sv
// ============================================================================
// sector_request_splitter_chs
// Splits byte-addressed requests into per-sector segments with CHS mapping.
//
//   port group   dir   handshake                    payload
//   s_axis_*     in    tvalid/tready                tdata, tuser
//   m_axis_*     out   tvalid/tready                tdata, tuser, tlast
//   APB          in    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A request is queued in the cycle it is accepted. The back part pops it
// from the queue, finds the first sector's track with the serial divider,
// then emits one segment per cycle unless the output stalls; a request
// gives at most 33 segments. Rejected and empty requests skip the divider.
// Reset clears the queue and control; registers return to their defaults.
// Output stalls hold the back part; the queue keeps accepting until full.
// ============================================================================
`default_nettype none

module sector_request_splitter_chs #(
    parameter int NUM_HEADS         = srsc_pkg::NUM_HEADS_DEF,
    parameter int MAX_REQUEST_BYTES = srsc_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [21:0] start_offset, [34:22] byte_count, [39:35] zero
    input  wire logic [srsc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [11:0] linear_sector, [22:12] cylinder_num, [23] head_num,
    // [29:24] sector_num, [39:30] offset_in_sector, [50:40] segment_bytes,
    // [55:51] zero
    output logic [srsc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] kind_echo, [2:1] status
    output logic [srsc_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    // last_flag
    output logic                                 m_axis_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srsc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [srsc_pkg::PDATA_W-1:0]    pwdata,
    output logic [srsc_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import srsc_pkg::*;

    logic [1:0]         size_code_reg;
    logic [SEC_W-1:0]   spt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;
    cfg_t               cfg;
    req_t               front_req;
    req_t               fifo_req;
    logic               fifo_full;
    logic               fifo_empty;
    logic               fifo_pop;
    res_t               res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_code_reg <= RST_SIZE_CODE;
            spt_reg       <= RST_SPT;
            total_reg     <= RST_TOTAL;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SIZE_CODE: size_code_reg <= pwdata[1:0];
                REG_SPT:       spt_reg       <= pwdata[SEC_W-1:0];
                REG_TOTAL:     total_reg     <= pwdata[TOTAL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SIZE_CODE: prdata = PDATA_W'(size_code_reg);
            REG_SPT:       prdata = PDATA_W'(spt_reg);
            REG_TOTAL:     prdata = PDATA_W'(total_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.size_code = size_code_reg;
        cfg.spt       = (spt_reg == '0) ? SEC_W'(1) : spt_reg;
        cfg.limit     = (total_reg > SECTOR_LIMIT) ? SECTOR_LIMIT : total_reg;
    end

    assign s_axis_tready = !fifo_full;

    srsc_front #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_front (
        .cfg          (cfg),
        .kind         (s_axis_tuser),
        .start_offset (s_axis_tdata[OFF_W-1:0]),
        .byte_count   (s_axis_tdata[OFF_W+LEN_W-1:OFF_W]),
        .req          (front_req)
    );

    srsc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s_axis_tvalid),
        .wr_data (front_req),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .rd_data (fifo_req),
        .empty   (fifo_empty)
    );

    srsc_back #(
        .NUM_HEADS (NUM_HEADS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (fifo_req),
        .req_empty (fifo_empty),
        .req_pop   (fifo_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = M_TDATA_W'({res.seg, res.offs, res.sector, res.head,
                                      res.cyl, res.linear});
    assign m_axis_tuser = {res.status, res.kind};
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> rtl/srsc_checker.sv
// ============================================================================
// srsc_checker
// Port-level checks on the splitter's result stream.
// ============================================================================
`default_nettype none

module srsc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [srsc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [srsc_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  wire logic                            m_axis_tlast
);
    import srsc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transfer dropped while stalled");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("error result not a lone zeroed transfer");

    a_seg_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == ST_OK
        |-> m_axis_tdata[50:40] != '0 && m_axis_tdata[29:24] != '0)
        else $error("ok segment with zero bytes or zero sector");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
        else $error("undefined status code");

endmodule

bind sector_request_splitter_chs srsc_checker u_srsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/srsc_checker.sv
// ============================================================================
// srsc_tb_checker
// Watches the request and segment streams and the register port of the
// sector request splitter. Every accepted request is split into the
// segments it should produce; each accepted segment is compared field by
// field against the oldest segment still due.
// ============================================================================
`default_nettype none

module srsc_tb_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    // [21:0] start_offset, [34:22] byte_count, [39:35] zero
    input  wire logic [srsc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                            s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [11:0] linear_sector, [22:12] cylinder_num, [23] head_num,
    // [29:24] sector_num, [39:30] offset_in_sector, [50:40] segment_bytes
    input  wire logic [srsc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] kind_echo, [2:1] status
    input  wire logic [srsc_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  wire logic                            m_axis_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [srsc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [srsc_pkg::PDATA_W-1:0]    pwdata,
    output int                                   mismatch_count,
    output int                                   segments_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srsc_pkg::*;

    logic [1:0]         size_code = RST_SIZE_CODE;
    logic [SEC_W-1:0]   spt       = RST_SPT;
    logic [TOTAL_W-1:0] total     = RST_TOTAL;

    res_t segments_due[$];
    res_t want;
    res_t got;
    bit   bad;
    int   mismatches = 0;
    int   pending    = 0;

    assign mismatch_count   = mismatches;
    assign segments_pending = pending;

    task automatic predict_segments(input logic kind, input logic [OFF_W-1:0] off,
                                    input logic [LEN_W-1:0] len);
        res_t seg_r;
        int   sect_bytes;
        int   per_track;
        int   limit;
        int   first_lin;
        int   last_lin;
        int   pos;
        int   rem;
        int   track;
        int   chunk;
        sect_bytes = 128 << size_code;
        per_track  = (spt == 0) ? 1 : int'(spt);
        limit      = (total > 4096) ? 4096 : int'(total);
        seg_r      = '0;
        seg_r.kind = kind;
        seg_r.last = 1'b1;
        if (len == 0) begin
            seg_r.status = ST_EMPTY;
            segments_due.push_back(seg_r);
        end else begin
            first_lin = int'(off) / sect_bytes;
            last_lin  = (int'(off) + int'(len) - 1) / sect_bytes;
            if (int'(len) > MAX_REQUEST_BYTES_DEF || last_lin >= limit) begin
                seg_r.status = ST_RANGE;
                segments_due.push_back(seg_r);
            end else begin
                pos = int'(off);
                rem = int'(len);
                for (int lin = first_lin; lin <= last_lin; lin++) begin
                    track = lin / per_track;
                    chunk = sect_bytes - pos % sect_bytes;
                    if (rem < chunk)
                        chunk = rem;
                    seg_r.linear = LIN_W'(lin);
                    seg_r.cyl    = CYL_W'(track / NUM_HEADS_DEF);
                    seg_r.head   = 1'(track % NUM_HEADS_DEF);
                    seg_r.sector = SEC_W'(lin % per_track + 1);
                    seg_r.offs   = OFFS_W'(pos % sect_bytes);
                    seg_r.seg    = SEG_W'(chunk);
                    seg_r.last   = (lin == last_lin);
                    seg_r.status = ST_OK;
                    segments_due.push_back(seg_r);
                    pos += chunk;
                    rem -= chunk;
                end
            end
        end
    endtask

    function automatic bit field_ok(input string name, input int unsigned expv,
                                    input int unsigned actv);
        if (expv != actv)
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, expv, actv);
        return expv == actv;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            size_code = RST_SIZE_CODE;
            spt       = RST_SPT;
            total     = RST_TOTAL;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SIZE_CODE: size_code = pwdata[1:0];
                REG_SPT:       spt       = pwdata[SEC_W-1:0];
                REG_TOTAL:     total     = pwdata[TOTAL_W-1:0];
                default: ;
            endcase
        end

        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_segments(s_axis_tuser, s_axis_tdata[OFF_W-1:0],
                             s_axis_tdata[OFF_W+LEN_W-1:OFF_W]);

        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (segments_due.size() == 0) begin
                mismatches++;
                $display("%0t unexpected segment: expected none, actual tdata=%h tuser=%h tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want       = segments_due.pop_front();
                got.kind   = m_axis_tuser[0];
                got.linear = m_axis_tdata[11:0];
                got.cyl    = m_axis_tdata[22:12];
                got.head   = m_axis_tdata[23];
                got.sector = m_axis_tdata[29:24];
                got.offs   = m_axis_tdata[39:30];
                got.seg    = m_axis_tdata[50:40];
                got.last   = m_axis_tlast;
                got.status = status_t'(m_axis_tuser[2:1]);
                bad = 1'b0;
                bad |= !field_ok("kind_echo", want.kind, got.kind);
                bad |= !field_ok("linear_sector", want.linear, got.linear);
                bad |= !field_ok("cylinder_num", want.cyl, got.cyl);
                bad |= !field_ok("head_num", want.head, got.head);
                bad |= !field_ok("sector_num", want.sector, got.sector);
                bad |= !field_ok("offset_in_sector", want.offs, got.offs);
                bad |= !field_ok("segment_bytes", want.seg, got.seg);
                bad |= !field_ok("last_flag", want.last, got.last);
                bad |= !field_ok("status", want.status, got.status);
                bad |= !field_ok("tdata pad", 0, m_axis_tdata[55:51]);
                if (bad)
                    mismatches++;
            end
        end

        pending = segments_due.size();
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ============================================================================
// testbench
// Drives byte-addressed requests into the sector request splitter under a
// series of sector size / geometry / capacity settings, with random source
// gaps and sink stalls, one long sink hold-off and one full drain pause.
// Checking is done by srsc_tb_checker; this module only stimulates and reports.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srsc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_PHASES      = 6;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int mismatch_count;
    int segments_pending;
    int cycle_count  = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;

    logic [1:0]         cur_code  = RST_SIZE_CODE;
    logic [TOTAL_W-1:0] cur_total = RST_TOTAL;

    sector_request_splitter_chs dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    srsc_tb_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (mismatch_count),
        .segments_pending (segments_pending)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sector_request_splitter_chs] ERROR");
            $finish;
        end
    end

    // segment sink: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            if (holds_served < holds_asked)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holds_served++;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input logic [1:0] code, input logic [SEC_W-1:0] spt,
                                input logic [TOTAL_W-1:0] total);
        write_reg(REG_SIZE_CODE, PDATA_W'(code));
        write_reg(REG_SPT, PDATA_W'(spt));
        write_reg(REG_TOTAL, PDATA_W'(total));
        cur_code  = code;
        cur_total = total;
    endtask

    task automatic send_request(input logic kind, input logic [OFF_W-1:0] off,
                                input logic [LEN_W-1:0] len);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, len, off};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_segments();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (segments_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_request();
        logic             kind;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        int               sect_bytes;
        int               disk_bytes;
        int               pick;
        int               o;
        kind       = 1'($urandom_range(0, 1));
        sect_bytes = 128 << cur_code;
        disk_bytes = ((cur_total > 4096) ? 4096 : int'(cur_total)) * sect_bytes;
        pick       = $urandom_range(0, 19);
        off        = OFF_W'($urandom);
        len        = LEN_W'($urandom_range(1, 4096));
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = LEN_W'($urandom_range(4097, 8191));
        else if (pick >= 4 && disk_bytes > 0)
        begin
            if (pick <= 5)
            begin
                // last byte right around the end of the medium
                o = disk_bytes - int'(len) + int'($urandom_range(0, 2)) - 1;
                off = OFF_W'((o < 0) ? 0 : o);
            end
            else
            begin
                if (pick <= 13)
                    len = LEN_W'($urandom_range(1, 2 * sect_bytes));
                if (disk_bytes > int'(len))
                    off = OFF_W'($urandom_range(0, disk_bytes - int'(len)));
                if ($urandom_range(0, 3) == 0)
                    off = off - OFF_W'(int'(off) % sect_bytes);
            end
        end
        send_request(kind, off, len);
    endtask

    initial
    begin
        int               count;
        logic [1:0]       code;
        logic [SEC_W-1:0] spt;
        logic [TOTAL_W-1:0] total;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 512-byte sectors, 18 per track, 2880 sectors
        send_request(1'b0, 22'd0, 13'd0);
        send_request(1'b1, 22'd4194303, 13'd0);
        send_request(1'b0, 22'd0, 13'd1);
        send_request(1'b1, 22'd0, 13'd4096);
        send_request(1'b0, 22'd511, 13'd2);
        send_request(1'b1, 22'd1, 13'd4096);
        send_request(1'b0, 22'd0, 13'd4097);
        send_request(1'b1, 22'd4194303, 13'd8191);
        send_request(1'b0, 22'd1474559, 13'd1);
        send_request(1'b1, 22'd1474048, 13'd512);
        send_request(1'b0, 22'd1474560, 13'd1);
        send_request(1'b1, 22'd1474559, 13'd2);
        send_request(1'b0, 22'd4194303, 13'd4096);
        send_request(1'b1, 22'd9215, 13'd2);
        send_request(1'b0, 22'd18431, 13'd2);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_segments();
            case (p)
                0: begin code = 2'd3; spt = 6'd63; total = 13'd4096; count = 60; end
                1: begin code = 2'd0; spt = 6'd0;  total = 13'd8191; count = 50; end
                2: begin code = 2'd1; spt = 6'd9;  total = 13'd100;  count = 50; end
                3: begin code = 2'd2; spt = 6'd1;  total = 13'd0;    count = 10; end
                4: begin code = 2'd0; spt = 6'd63; total = 13'd1;    count = 15; end
                default:
                begin
                    code      = 2'($urandom_range(0, 3));
                    spt       = SEC_W'($urandom_range(1, 63));
                    total     = TOTAL_W'($urandom_range(1, 4096));
                    count     = 60;
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
            endcase
            set_geometry(code, spt, total);
            // unaligned maximum request: most segments for the sector size
            send_request(1'($urandom_range(0, 1)), OFF_W'((128 << code) - 1), 13'd4096);
            for (int i = 0; i < count; i++)
            begin
                if (p == 0 && i == 0)
                    holds_asked++;
                if (p == 2 && i == count / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                    wait (segments_pending == 0);
                end
                random_request();
            end
        end

        drain_segments();
        if (mismatch_count == 0 && segments_pending == 0)
            $display("[sector_request_splitter_chs] OK");
        else
            $display("[sector_request_splitter_chs] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/srsc_pkg.sv
rtl/srsc_front.sv
rtl/srsc_fifo.sv
rtl/srsc_back.sv
rtl/sector_request_splitter_chs.sv
rtl/srsc_checker.sv
tb/srsc_checker.sv
tb/testbench.sv
